// ===== rtl/core/acm_pkg.sv =====
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types, field widths and codes of the Aho-Corasick trie matcher.
// ----------------------------------------------------------------------------
package acm_pkg;

  // Default sizes of the trie
  localparam int unsigned NODES_DEF    = 4096;
  localparam int unsigned ALPHABET_DEF = 26;

  // Fixed field widths
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned SYM_W      = 5;
  localparam int unsigned NODE_OUT_W = 12;
  localparam int unsigned CNT_W      = 16;

  // Command codes as they arrive on the cmd field
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_ERASE  = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_BUILD  = 3'd3,
    CMD_SCAN   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  // Decoded operation handed from front to engine
  typedef enum logic [2:0] {
    OP_INSERT,
    OP_ERASE,
    OP_FIND,
    OP_BUILD,
    OP_SCAN,
    OP_CLEAR,
    OP_BAD
  } op_e;

  // Engine sequencer states
  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_W1,
    S_W2,
    S_SC1,
    S_SC2,
    S_BCLR,
    S_BINIT,
    S_BPOP,
    S_BX,
    S_BLX,
    S_BOR,
    S_BE1,
    S_BE2,
    S_BE3,
    S_BEND
  } eng_state_e;

  // Input item
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } item_in_t;

  // Result item
  typedef struct packed {
    logic [NODE_OUT_W-1:0] node_reached;
    logic [CNT_W-1:0]      hit_count;
    logic                  found;
    logic                  error;
  } result_t;

  // Classified item between front and engine
  typedef struct packed {
    op_e              op;
    logic [SYM_W-1:0] sym;
    logic             sym_ok;
    logic             last;
  } op_t;

endpackage

// ===== rtl/core/aho_corasick_trie_matcher.sv =====
// ----------------------------------------------------------------------------
// aho_corasick_trie_matcher
// Trie with insert, erase, find, failure-link build, text scan and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on push/full with item_i (cmd, symbol, last). Results leave on
//   empty/pop with result_o; exactly one result per item, in order.
//   A front queue of two decoded items decouples the input from the engine;
//   a two-entry result queue decouples the engine from the receiver.
//   Engine steps per item: insert, erase, find and an in-range scan make two
//   dependent memory reads; a walk that fails at its edge read or an
//   out-of-range scan makes only the first, and an unknown command is
//   answered as it is taken.
//   Build: take the item, clear the visited marks of all NODES nodes, seed
//   the root, then per visited node read it and its failure node and go
//   over its letters in turn, paced by the single read port of the edge
//   memory, and finish. Clear: take the item, then sweep one edge entry
//   per cycle. After reset the same sweep runs and full stays high until
//   it ends. If the receiver stalls, the result queue fills and the engine
//   stops taking items; the front queue then fills and full rises.
// ----------------------------------------------------------------------------
module aho_corasick_trie_matcher #(
  parameter int unsigned NODES    = acm_pkg::NODES_DEF,
  parameter int unsigned ALPHABET = acm_pkg::ALPHABET_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  acm_pkg::item_in_t item_i,
  output logic              empty,
  input  logic              pop,
  output acm_pkg::result_t  result_o
);
  import acm_pkg::*;

  logic    front_full, init_busy, acc;
  logic    op_valid, op_pop, res_full, res_push;
  op_t     op;
  result_t res;

  assign full = front_full || init_busy;
  assign acc  = push && !full;

  acm_front #(
    .ALPHABET (ALPHABET)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (acc),
    .item_i     (item_i),
    .full_o     (front_full),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  acm_engine #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_pop_o    (op_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res),
    .init_busy_o (init_busy)
  );

  acm_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (result_o)
  );

endmodule

// ===== rtl/core/acm_front.sv =====
// ----------------------------------------------------------------------------
// acm_front
// Accepts items, decodes the command, checks the symbol range and holds the
// classified items in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module acm_front #(
  parameter int unsigned ALPHABET = acm_pkg::ALPHABET_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  acm_pkg::item_in_t item_i,
  output logic             full_o,
  output logic             op_valid_o,
  output acm_pkg::op_t     op_o,
  input  logic             op_pop_i
);
  import acm_pkg::*;

  op_t        dec;
  op_t        slot_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  // Classify the incoming item
  always_comb begin
    dec.sym    = item_i.symbol;
    dec.last   = item_i.last;
    dec.sym_ok = (32'(item_i.symbol) < 32'(ALPHABET));
    unique case (item_i.cmd)
      CMD_INSERT: dec.op = OP_INSERT;
      CMD_ERASE:  dec.op = OP_ERASE;
      CMD_FIND:   dec.op = OP_FIND;
      CMD_BUILD:  dec.op = OP_BUILD;
      CMD_SCAN:   dec.op = OP_SCAN;
      CMD_CLEAR:  dec.op = OP_CLEAR;
      default:    dec.op = OP_BAD;
    endcase
  end

  // Queue pointers
  assign do_pop     = op_pop_i && (cnt_q != 2'd0);
  assign full_o     = (cnt_q == 2'd2);
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (do_pop) begin
      rptr_d = ~rptr_q;
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= dec;
    end
  end

endmodule

// ===== rtl/core/acm_resq.sv =====
// ----------------------------------------------------------------------------
// acm_resq
// Two-entry result queue between the engine and the result port.
// ----------------------------------------------------------------------------
module acm_resq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  acm_pkg::result_t res_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output acm_pkg::result_t res_o
);
  import acm_pkg::*;

  result_t    slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = slot_q[rptr_q];
  assign cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, do_pop};

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= res_i;
    end
  end

endmodule

// ===== rtl/core/acm_engine.sv =====
// ----------------------------------------------------------------------------
// acm_engine
// Back end: sequencer over the trie memories. Runs walks, scans, the
// breadth-first link build and the clearing sweep, one item at a time.
// ----------------------------------------------------------------------------
module acm_engine #(
  parameter int unsigned NODES    = acm_pkg::NODES_DEF,
  parameter int unsigned ALPHABET = acm_pkg::ALPHABET_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             op_valid_i,
  input  acm_pkg::op_t     op_i,
  output logic             op_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output acm_pkg::result_t res_o,
  output logic             init_busy_o
);
  import acm_pkg::*;

  localparam int unsigned NODE_W = $clog2(NODES);
  localparam int unsigned EA_W   = $clog2(NODES * ALPHABET);
  localparam int unsigned I_W    = $clog2(ALPHABET);
  localparam int unsigned NF_W   = NODE_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Flat edge address: node * ALPHABET + letter
  function automatic logic [EA_W-1:0] edge_addr(input logic [NODE_W-1:0] node,
                                                input logic [EA_W-1:0]   idx);
    edge_addr = EA_W'(node) * EA_W'(ALPHABET) + idx;
  endfunction

  // Memories
  logic [NODE_W-1:0] edge_mem [NODES*ALPHABET];
  logic [CNT_W-1:0]  end_mem  [NODES];
  logic [CNT_W-1:0]  pfx_mem  [NODES];
  logic [NODE_W-1:0] fail_mem [NODES];
  logic [NODE_W-1:0] q_mem    [NODES];
  logic              seen_mem [NODES];

  // Memory ports
  logic              edge_we, end_we, pfx_we, fail_we, q_we, seen_we;
  logic [EA_W-1:0]   edge_wa, edge_ra;
  logic [NODE_W-1:0] end_wa, end_ra, pfx_wa, pfx_ra, fail_wa, fail_ra;
  logic [NODE_W-1:0] q_wa, q_ra, seen_wa, seen_ra;
  logic [NODE_W-1:0] edge_wd, fail_wd, q_wd;
  logic [CNT_W-1:0]  end_wd, pfx_wd;
  logic              seen_wd;
  logic [NODE_W-1:0] edge_rd_q, fail_rd_q, q_rd_q;
  logic [CNT_W-1:0]  end_rd_q, pfx_rd_q;
  logic              seen_rd_q;

  // Sequencer registers
  eng_state_e        state_q, state_d;
  op_t               op_q, op_d;
  logic [NODE_W-1:0] w_q, w_d, scan_q, scan_d, child_q, child_d;
  logic              wf_q, wf_d, err_q, err_d, clr_res_q, clr_res_d;
  logic [NF_W-1:0]   nf_q, nf_d, head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  endw_q, endw_d, endx_q, endx_d;
  logic [NODE_W-1:0] x_q, x_d, lx_q, lx_d, y_q, y_d;
  logic [I_W-1:0]    i_q, i_d;
  logic [EA_W-1:0]   clr_q, clr_d;

  // Walk bookkeeping
  logic              walk_upd, nfail;
  logic [NODE_W-1:0] nw, child;
  logic              take, trie_full, w1_stop, new_node, clr_last, i_last;
  logic [CNT_W-1:0]  newend;

  assign take      = op_valid_i && !res_full_i;
  assign trie_full = (nf_q >= NF_W'(NODES));
  assign new_node  = (op_q.op == OP_INSERT) && (edge_rd_q == '0);
  assign w1_stop   = wf_q || !op_q.sym_ok || (new_node && trie_full);
  assign clr_last  = (clr_q == EA_W'(NODES * ALPHABET - 1));
  assign i_last    = (i_q == I_W'(ALPHABET - 1));
  assign newend    = (op_q.last && (end_rd_q != CNT_MAX)) ? end_rd_q + 1'b1 : end_rd_q;
  assign child     = new_node ? nf_q[NODE_W-1:0] : edge_rd_q;
  assign init_busy_o = (state_q == S_INIT) && !clr_res_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:  if (clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (take) begin
          unique case (op_i.op)
            OP_INSERT, OP_ERASE, OP_FIND: state_d = S_W1;
            OP_SCAN:  state_d = op_i.sym_ok ? S_SC1 : S_SC2;
            OP_BUILD: state_d = S_BCLR;
            OP_CLEAR: state_d = S_INIT;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_W1:    state_d = w1_stop ? S_IDLE : S_W2;
      S_W2:    state_d = S_IDLE;
      S_SC1:   state_d = S_SC2;
      S_SC2:   state_d = S_IDLE;
      S_BCLR:  if (clr_q == EA_W'(NODES - 1)) state_d = S_BINIT;
      S_BINIT: state_d = S_BPOP;
      S_BPOP:  state_d = (head_q < tail_q) ? S_BX : S_BEND;
      S_BX:    state_d = S_BLX;
      S_BLX:   state_d = S_BOR;
      S_BOR:   state_d = S_BE1;
      S_BE1:   state_d = S_BE2;
      S_BE2:   state_d = S_BE3;
      S_BE3:   state_d = i_last ? S_BPOP : S_BE1;
      S_BEND:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory control and results
  always_comb begin
    op_d = op_q;  w_d = w_q;  wf_d = wf_q;  scan_d = scan_q;  child_d = child_q;
    err_d = err_q;  clr_res_d = clr_res_q;  nf_d = nf_q;  head_d = head_q;
    tail_d = tail_q;  endw_d = endw_q;  endx_d = endx_q;  x_d = x_q;  lx_d = lx_q;
    y_d = y_q;  i_d = i_q;  clr_d = clr_q;
    edge_we = 1'b0; end_we = 1'b0; pfx_we = 1'b0; fail_we = 1'b0;
    q_we = 1'b0; seen_we = 1'b0;
    edge_wa = '0; edge_ra = '0; end_wa = '0; end_ra = '0; pfx_wa = '0; pfx_ra = '0;
    fail_wa = '0; fail_ra = '0; q_wa = '0; q_ra = '0; seen_wa = '0; seen_ra = '0;
    edge_wd = '0; fail_wd = '0; q_wd = '0; end_wd = '0; pfx_wd = '0; seen_wd = 1'b0;
    op_pop_o = 1'b0; res_push_o = 1'b0; res_o = '0;
    walk_upd = 1'b0; nfail = wf_q; nw = w_q;

    unique case (state_q)
      // Clearing sweep after reset or a clear command
      S_INIT: begin
        edge_we = 1'b1;
        edge_wa = clr_q;
        if (clr_q < EA_W'(NODES)) begin
          end_we  = 1'b1;  end_wa  = clr_q[NODE_W-1:0];
          pfx_we  = 1'b1;  pfx_wa  = clr_q[NODE_W-1:0];
          fail_we = 1'b1;  fail_wa = clr_q[NODE_W-1:0];
        end
        clr_d = clr_q + 1'b1;
        if (clr_last) begin
          clr_d = '0;  nf_d = NF_W'(1);  w_d = '0;  wf_d = 1'b0;  scan_d = '0;
          clr_res_d  = 1'b0;
          res_push_o = clr_res_q;
        end
      end

      // Take the next item and issue its first reads; an unknown command is answered here with an error
      S_IDLE: begin
        if (take) begin
          op_pop_o = 1'b1;
          op_d     = op_i;
          unique case (op_i.op)
            OP_INSERT, OP_ERASE, OP_FIND: begin
              edge_ra = op_i.sym_ok ? edge_addr(w_q, EA_W'(op_i.sym)) : '0;
              end_ra  = w_q;
            end
            OP_SCAN: begin
              if (op_i.sym_ok) begin
                edge_ra = edge_addr(scan_q, EA_W'(op_i.sym));
                err_d   = 1'b0;
              end else begin
                scan_d = '0;
                err_d  = 1'b1;
                end_ra = '0;
              end
            end
            OP_BUILD: clr_d = '0;
            OP_CLEAR: begin
              clr_d     = '0;
              clr_res_d = 1'b1;
            end
            default: begin
              res_push_o = 1'b1;
              res_o.error = 1'b1;
            end
          endcase
        end
      end

      // Walk: edge and current end count are in
      S_W1: begin
        endw_d = end_rd_q;
        if (w1_stop) begin
          nfail = 1'b1;
          walk_upd = 1'b1;
          res_push_o = 1'b1;
          res_o.node_reached = NODE_OUT_W'(w_q);
          res_o.hit_count = end_rd_q;
          res_o.error = (op_q.op != OP_FIND) || !op_q.sym_ok || new_node;
        end else begin
          if (new_node) begin
            edge_we = 1'b1;
            edge_wa = edge_addr(w_q, EA_W'(op_q.sym));
            edge_wd = child;
            nf_d    = nf_q + 1'b1;
          end
          child_d = child;
          pfx_ra  = child;
          end_ra  = child;
        end
      end

      // Walk: counts of the child are in
      S_W2: begin
        walk_upd = 1'b1;
        res_push_o = 1'b1;
        res_o.node_reached = NODE_OUT_W'(child_q);
        res_o.hit_count = end_rd_q;
        unique case (op_q.op)
          OP_INSERT: begin
            pfx_we = 1'b1;  pfx_wa = child_q;
            pfx_wd = (pfx_rd_q == CNT_MAX) ? pfx_rd_q : pfx_rd_q + 1'b1;
            end_we = op_q.last;  end_wa = child_q;  end_wd = newend;
            res_o.hit_count = newend;
            nw = child_q;
          end
          OP_ERASE: begin
            if (pfx_rd_q == '0) begin
              nfail = 1'b1;
              res_o.node_reached = NODE_OUT_W'(w_q);
              res_o.hit_count = endw_q;
              res_o.error = 1'b1;
            end else begin
              pfx_we = 1'b1;  pfx_wa = child_q;  pfx_wd = pfx_rd_q - 1'b1;
              nw = child_q;
              if (op_q.last) begin
                if (end_rd_q == '0) begin
                  nfail = 1'b1;
                  res_o.error = 1'b1;
                end else begin
                  end_we = 1'b1;  end_wa = child_q;  end_wd = end_rd_q - 1'b1;
                  res_o.hit_count = end_rd_q - 1'b1;
                end
              end
            end
          end
          OP_FIND: begin
            if (pfx_rd_q == '0) begin
              nfail = 1'b1;
              res_o.node_reached = NODE_OUT_W'(w_q);
              res_o.hit_count = endw_q;
            end else begin
              nw = child_q;
              res_o.found = op_q.last;
            end
          end
          default: res_o.error = 1'b1;
        endcase
      end

      // Scan: next node known, fetch its end count
      S_SC1: begin
        scan_d = edge_rd_q;
        end_ra = edge_rd_q;
      end

      S_SC2: begin
        res_push_o = 1'b1;
        res_o.node_reached = NODE_OUT_W'(scan_q);
        res_o.hit_count = end_rd_q;
        res_o.error = err_q;
      end

      // Build: clear visited marks
      S_BCLR: begin
        seen_we = 1'b1;
        seen_wa = clr_q[NODE_W-1:0];
        clr_d   = clr_q + 1'b1;
        if (clr_q == EA_W'(NODES - 1)) clr_d = '0;
      end

      // Build: enqueue the root
      S_BINIT: begin
        seen_we = 1'b1;  seen_wa = '0;  seen_wd = 1'b1;
        q_we    = 1'b1;  q_wa    = '0;  q_wd    = '0;
        head_d  = '0;
        tail_d  = NF_W'(1);
      end

      S_BPOP: begin
        if (head_q < tail_q) begin
          q_ra   = head_q[NODE_W-1:0];
          head_d = head_q + 1'b1;
        end else begin
          end_ra = '0;
        end
      end

      S_BX: begin
        x_d     = q_rd_q;
        fail_ra = q_rd_q;
        end_ra  = q_rd_q;
      end

      S_BLX: begin
        lx_d   = fail_rd_q;
        endx_d = end_rd_q;
        end_ra = fail_rd_q;
      end

      // Merge end count with the failure node
      S_BOR: begin
        end_we = 1'b1;
        end_wa = x_q;
        end_wd = endx_q | end_rd_q;
        i_d    = '0;
      end

      S_BE1: edge_ra = edge_addr(x_q, EA_W'(i_q));

      S_BE2: begin
        y_d     = edge_rd_q;
        edge_ra = edge_addr(lx_q, EA_W'(i_q));
        seen_ra = edge_rd_q;
      end

      // Enqueue a fresh child or fill a goto edge
      S_BE3: begin
        if (y_q != '0) begin
          if (!seen_rd_q && (tail_q < NF_W'(NODES))) begin
            seen_we = 1'b1;  seen_wa = y_q;  seen_wd = 1'b1;
            q_we    = 1'b1;  q_wa    = tail_q[NODE_W-1:0];  q_wd = y_q;
            tail_d  = tail_q + 1'b1;
            fail_we = 1'b1;  fail_wa = y_q;
            fail_wd = (x_q != '0) ? edge_rd_q : '0;
          end
        end else begin
          edge_we = 1'b1;
          edge_wa = edge_addr(x_q, EA_W'(i_q));
          edge_wd = edge_rd_q;
        end
        i_d = i_q + 1'b1;
      end

      S_BEND: begin
        res_push_o = 1'b1;
        res_o.hit_count = end_rd_q;
      end

      default: ;
    endcase

    // Walk state update; last symbol ends the walk
    if (walk_upd) begin
      if (op_q.last) begin
        w_d  = '0;
        wf_d = 1'b0;
      end else begin
        w_d  = nw;
        wf_d = nfail;
      end
    end
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      clr_q     <= '0;
      clr_res_q <= 1'b0;
      nf_q      <= NF_W'(1);
      w_q       <= '0;
      wf_q      <= 1'b0;
      scan_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      i_q       <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_res_q <= clr_res_d;
      nf_q      <= nf_d;
      w_q       <= w_d;
      wf_q      <= wf_d;
      scan_q    <= scan_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      i_q       <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    child_q <= child_d;
    err_q   <= err_d;
    endw_q  <= endw_d;
    endx_q  <= endx_d;
    x_q     <= x_d;
    lx_q    <= lx_d;
    y_q     <= y_d;
  end

  // Edge memory
  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    edge_rd_q <= edge_mem[edge_ra];
  end

  // Per-node memories
  always_ff @(posedge clk_i) begin
    if (end_we) end_mem[end_wa] <= end_wd;
    end_rd_q <= end_mem[end_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pfx_we) pfx_mem[pfx_wa] <= pfx_wd;
    pfx_rd_q <= pfx_mem[pfx_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_rd_q <= fail_mem[fail_ra];
  end

  // Breadth-first queue and visited marks
  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_q <= q_mem[q_ra];
  end

  always_ff @(posedge clk_i) begin
    if (seen_we) seen_mem[seen_wa] <= seen_wd;
    seen_rd_q <= seen_mem[seen_ra];
  end

endmodule

// ===== rtl/core/acm_checker.sv =====
// ----------------------------------------------------------------------------
// acm_checker
// Port-level checks of the trie matcher, bound to the top level.
// ----------------------------------------------------------------------------
module acm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input acm_pkg::result_t  result_o
);
  import acm_pkg::*;

  logic [3:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  // Items taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {3'd0, in_acc} - {3'd0, out_acc};
    end
  end

  // No result without an item behind it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pend_q != 4'd0))
    else $error("result delivered with no item outstanding");

  // Find hit and error never come together
  a_found_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(result_o.found && result_o.error))
    else $error("found and error both set");

  // A waiting result stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  // and keeps its value
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(result_o))
    else $error("waiting result changed");

endmodule

bind aho_corasick_trie_matcher acm_checker u_acm_checker (.*);
